@@ hw/rtl/ufef_pkg.sv @@
// ----------------------------------------------------------------------------
// ufef_pkg
// shared widths, register indexes, datapath op codes and the control/status
// bundles of the union-find edge filter
// ----------------------------------------------------------------------------
package ufef_pkg;

   localparam int DEF_MAX_NODES = 512;

   localparam int NODE_COUNT_W = 10;
   localparam int END_W        = 9;
   localparam int LEN_W        = 32;
   localparam int TREE_W       = 9;
   localparam int RANK_W       = 4;

   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SATELLITE_COUNT = 1'b1;

   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET      = 10'd2;
   localparam logic [NODE_COUNT_W-1:0] SATELLITE_COUNT_RESET = 10'd1;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
   localparam logic [OP_W-1:0] OP_CLR        = 4'd2;
   localparam logic [OP_W-1:0] OP_WALK_START = 4'd3;
   localparam logic [OP_W-1:0] OP_WALK       = 4'd4;
   localparam logic [OP_W-1:0] OP_COMP       = 4'd5;
   localparam logic [OP_W-1:0] OP_LINK       = 4'd6;
   localparam logic [OP_W-1:0] OP_BUMP       = 4'd7;
   localparam logic [OP_W-1:0] OP_RESULT     = 4'd8;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            side;
   } ufef_cmd_type;

   typedef struct packed {
      logic is_new;
      logic in_range;
      logic walk_done;
      logic comp_done;
      logic roots_differ;
      logic need_bump;
      logic clr_last;
   } ufef_status_type;

endpackage

@@ hw/rtl/ufef_if.sv @@
// ----------------------------------------------------------------------------
// ufef_if
// valid/ready channels for edge requests and filter responses
// ----------------------------------------------------------------------------
interface ufef_req_if import ufef_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             new_graph;
   logic [END_W-1:0] end_a;
   logic [END_W-1:0] end_b;
   logic [LEN_W-1:0] edge_length;

   modport source (output valid, new_graph, end_a, end_b, edge_length, input ready);
   modport sink   (input valid, new_graph, end_a, end_b, edge_length, output ready);
endinterface

interface ufef_rsp_if import ufef_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              joined;
   logic              is_answer;
   logic [LEN_W-1:0]  length_out;
   logic [TREE_W-1:0] tree_edges;
   logic              tree_complete;

   modport source (output valid, joined, is_answer, length_out, tree_edges, tree_complete,
                   input ready);
   modport sink   (input valid, joined, is_answer, length_out, tree_edges, tree_complete,
                   output ready);
endinterface

@@ hw/rtl/ufef_store.sv @@
// ----------------------------------------------------------------------------
// ufef_store
// single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module ufef_store import ufef_pkg::*; #(
   parameter int DEPTH = DEF_MAX_NODES,
   parameter int WIDTH = RANK_W + 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ufef_datapath.sv @@
// ----------------------------------------------------------------------------
// ufef_datapath
// config registers, item registers, parent/rank store, root walk and
// compression pointers, tree edge counter and response register
// ----------------------------------------------------------------------------
module ufef_datapath import ufef_pkg::*; #(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic                    new_graph,
   input  logic [END_W-1:0]        end_a,
   input  logic [END_W-1:0]        end_b,
   input  logic [LEN_W-1:0]        edge_length,
   input  ufef_cmd_type            cmd,
   output ufef_status_type         status,
   output logic                    joined,
   output logic                    is_answer,
   output logic [LEN_W-1:0]        length_out,
   output logic [TREE_W-1:0]       tree_edges,
   output logic                    tree_complete
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int EW  = NW + RANK_W;
   localparam int NCW = (NW + 1 > NODE_COUNT_W) ? NW + 1 : NODE_COUNT_W;

   // control state
   logic [NODE_COUNT_W-1:0] node_count_ff, node_count_in;
   logic [NODE_COUNT_W-1:0] sat_count_ff, sat_count_in;
   logic [NW-1:0]           count_ff, count_in;
   logic [NW-1:0]           clr_ff, clr_in;

   // payload
   logic [END_W-1:0]  a_ff, a_in;
   logic [END_W-1:0]  b_ff, b_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [NW-1:0]     root_ff, root_in;
   logic [NW-1:0]     cur_ff, cur_in;
   logic [NW-1:0]     ra_ff, ra_in;
   logic [NW-1:0]     rb_ff, rb_in;
   logic [RANK_W-1:0] rank_a_ff, rank_a_in;
   logic [RANK_W-1:0] rank_b_ff, rank_b_in;
   logic              joined_ff, joined_in;
   logic              answer_ff, answer_in;
   logic              joined_out_ff, joined_out_in;
   logic              answer_out_ff, answer_out_in;
   logic [LEN_W-1:0]  len_out_ff, len_out_in;
   logic [TREE_W-1:0] tree_out_ff, tree_out_in;
   logic              complete_out_ff, complete_out_in;

   // store port
   logic          wr_en;
   logic [NW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [NW-1:0] rd_addr;
   logic [EW-1:0] rd_data;

   logic [NCW-1:0]          nc_ext, n_ext, n_m1, a_ext, b_ext, count_ext;
   logic [NODE_COUNT_W-1:0] ans_idx;
   logic                    answer_hit;
   logic [NW-1:0]           a_idx, b_idx, v_idx;
   logic [NW-1:0]           rd_par;
   logic [RANK_W-1:0]       rd_rank;

   ufef_store #(
      .DEPTH (MAX_NODES),
      .WIDTH (EW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // effective node count, limited to 1 .. MAX_NODES
   always_comb begin
      nc_ext = NCW'(node_count_ff);
      if (nc_ext > NCW'(MAX_NODES)) begin
         n_ext = NCW'(MAX_NODES);
      end else if (nc_ext == '0) begin
         n_ext = NCW'(1);
      end else begin
         n_ext = nc_ext;
      end
   end

   assign n_m1      = n_ext - NCW'(1);
   assign a_ext     = NCW'(a_ff);
   assign b_ext     = NCW'(b_ff);
   assign count_ext = NCW'(count_ff);
   assign a_idx     = a_ext[NW-1:0];
   assign b_idx     = b_ext[NW-1:0];
   assign v_idx     = cmd.side ? b_idx : a_idx;
   assign rd_par    = rd_data[NW-1:0];
   assign rd_rank   = rd_data[EW-1:NW];

   assign ans_idx    = node_count_ff - sat_count_ff - NODE_COUNT_W'(1);
   assign answer_hit = (sat_count_ff < node_count_ff) && (NCW'(ans_idx) == count_ext);

   assign status.is_new       = new_graph;
   assign status.in_range     = (a_ext < n_ext) && (b_ext < n_ext) && (count_ext < n_m1);
   assign status.walk_done    = (rd_par == root_ff);
   assign status.comp_done    = (cur_ff == root_ff);
   assign status.roots_differ = (ra_ff != rb_ff);
   assign status.need_bump    = (rank_a_ff == rank_b_ff) && (rank_b_ff != RANK_MAX);
   assign status.clr_last     = (clr_ff == NW'(MAX_NODES - 1));

   // store addressing
   always_comb begin
      rd_addr = v_idx;
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = {RANK_W'(0), clr_ff};
      unique case (cmd.op)
         OP_CLR: begin
            wr_en = 1'b1;
         end
         OP_WALK: begin
            rd_addr = status.walk_done ? v_idx : rd_par;
         end
         OP_COMP: begin
            rd_addr = rd_par;
            wr_en   = !status.comp_done;
            wr_addr = cur_ff;
            wr_data = {rd_rank, root_ff};
         end
         OP_LINK: begin
            wr_en = 1'b1;
            if (rank_a_ff > rank_b_ff) begin
               wr_addr = rb_ff;
               wr_data = {rank_b_ff, ra_ff};
            end else begin
               wr_addr = ra_ff;
               wr_data = {rank_a_ff, rb_ff};
            end
         end
         OP_BUMP: begin
            wr_en   = 1'b1;
            wr_addr = rb_ff;
            wr_data = {rank_b_ff + RANK_W'(1), rb_ff};
         end
         default: begin
         end
      endcase
   end

   // next values
   always_comb begin
      node_count_in   = node_count_ff;
      sat_count_in    = sat_count_ff;
      count_in        = count_ff;
      clr_in          = clr_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      len_in          = len_ff;
      root_in         = root_ff;
      cur_in          = cur_ff;
      ra_in           = ra_ff;
      rb_in           = rb_ff;
      rank_a_in       = rank_a_ff;
      rank_b_in       = rank_b_ff;
      joined_in       = joined_ff;
      answer_in       = answer_ff;
      joined_out_in   = joined_out_ff;
      answer_out_in   = answer_out_ff;
      len_out_in      = len_out_ff;
      tree_out_in     = tree_out_ff;
      complete_out_in = complete_out_ff;

      if (csr_write) begin
         if (csr_index == CSR_NODE_COUNT) begin
            node_count_in = csr_data;
         end else if (csr_index == CSR_SATELLITE_COUNT) begin
            sat_count_in = csr_data;
         end
      end

      unique case (cmd.op)
         OP_LOAD: begin
            a_in      = end_a;
            b_in      = end_b;
            len_in    = edge_length;
            joined_in = 1'b0;
            answer_in = 1'b0;
         end
         OP_CLR: begin
            count_in = '0;
            clr_in   = status.clr_last ? '0 : clr_ff + NW'(1);
         end
         OP_WALK_START: begin
            root_in = v_idx;
         end
         OP_WALK: begin
            if (!status.walk_done) begin
               root_in = rd_par;
            end else begin
               cur_in = v_idx;
               if (cmd.side) begin
                  rb_in     = root_ff;
                  rank_b_in = rd_rank;
               end else begin
                  ra_in     = root_ff;
                  rank_a_in = rd_rank;
               end
            end
         end
         OP_COMP: begin
            if (!status.comp_done) begin
               cur_in = rd_par;
            end
         end
         OP_LINK: begin
            joined_in = 1'b1;
            answer_in = answer_hit;
            count_in  = count_ff + NW'(1);
         end
         OP_RESULT: begin
            joined_out_in   = joined_ff;
            answer_out_in   = answer_ff;
            len_out_in      = len_ff;
            tree_out_in     = count_ext[TREE_W-1:0];
            complete_out_in = (count_ext >= n_m1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         sat_count_ff  <= SATELLITE_COUNT_RESET;
         count_ff      <= '0;
         clr_ff        <= '0;
      end else begin
         node_count_ff <= node_count_in;
         sat_count_ff  <= sat_count_in;
         count_ff      <= count_in;
         clr_ff        <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff            <= a_in;
      b_ff            <= b_in;
      len_ff          <= len_in;
      root_ff         <= root_in;
      cur_ff          <= cur_in;
      ra_ff           <= ra_in;
      rb_ff           <= rb_in;
      rank_a_ff       <= rank_a_in;
      rank_b_ff       <= rank_b_in;
      joined_ff       <= joined_in;
      answer_ff       <= answer_in;
      joined_out_ff   <= joined_out_in;
      answer_out_ff   <= answer_out_in;
      len_out_ff      <= len_out_in;
      tree_out_ff     <= tree_out_in;
      complete_out_ff <= complete_out_in;
   end

   assign joined        = joined_out_ff;
   assign is_answer     = answer_out_ff;
   assign length_out    = len_out_ff;
   assign tree_edges    = tree_out_ff;
   assign tree_complete = complete_out_ff;

endmodule

@@ hw/rtl/ufef_ctrl.sv @@
// ----------------------------------------------------------------------------
// ufef_ctrl
// sequencer: store clear, two root walks with compression, union by rank,
// response handoff
// ----------------------------------------------------------------------------
module ufef_ctrl import ufef_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ufef_status_type status,
   output ufef_cmd_type    cmd
);

   localparam int SW = 4;
   localparam logic [SW-1:0] S_BOOT   = 4'd0;
   localparam logic [SW-1:0] S_IDLE   = 4'd1;
   localparam logic [SW-1:0] S_CLR    = 4'd2;
   localparam logic [SW-1:0] S_CHECK  = 4'd3;
   localparam logic [SW-1:0] S_WSTART = 4'd4;
   localparam logic [SW-1:0] S_WALK   = 4'd5;
   localparam logic [SW-1:0] S_COMP   = 4'd6;
   localparam logic [SW-1:0] S_UNION  = 4'd7;
   localparam logic [SW-1:0] S_BUMP   = 4'd8;
   localparam logic [SW-1:0] S_OUT    = 4'd9;

   logic [SW-1:0] state_ff, state_in;
   logic          side_ff, side_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.side     = side_ff;
      unique case (state_ff)
         S_BOOT: begin
            cmd.op = OP_CLR;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = status.is_new ? S_CLR : S_CHECK;
            end
         end
         S_CLR: begin
            cmd.op = OP_CLR;
            if (status.clr_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            side_in  = 1'b0;
            state_in = status.in_range ? S_WSTART : S_OUT;
         end
         S_WSTART: begin
            cmd.op   = OP_WALK_START;
            state_in = S_WALK;
         end
         S_WALK: begin
            cmd.op = OP_WALK;
            if (status.walk_done) begin
               state_in = S_COMP;
            end
         end
         S_COMP: begin
            cmd.op = OP_COMP;
            if (status.comp_done) begin
               if (side_ff) begin
                  state_in = S_UNION;
               end else begin
                  side_in  = 1'b1;
                  state_in = S_WSTART;
               end
            end
         end
         S_UNION: begin
            if (status.roots_differ) begin
               cmd.op   = OP_LINK;
               state_in = status.need_bump ? S_BUMP : S_OUT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_BUMP: begin
            cmd.op   = OP_BUMP;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/kruskal_union_find_edge_filter_top.sv @@
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter_top
// kruskal edge filter: disjoint-set store with union by rank and path
// compression, tree edge count and answer edge marking
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        new_graph, end_a, end_b, edge_length
//   rsp_chan  out   valid/ready        joined, is_answer, length_out,
//                                      tree_edges, tree_complete
//   csr_*     in    csr_write          csr_index, csr_data
//
// one edge at a time; an item walks and compresses the paths of end_a
// and then end_b to their roots, links the roots and bumps a rank on a
// tie below RANK_MAX; an ignored edge skips this; new_graph first clears
// all MAX_NODES entries. the one-write, one-read parent/rank store sets
// the pace: one hop per cycle. after reset the store is cleared before
// req_chan.ready rises; a new item is taken while the last response waits.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter_top import ufef_pkg::*; #(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   ufef_req_if.sink              req_chan,
   ufef_rsp_if.source            rsp_chan
);

   ufef_cmd_type    cmd;
   ufef_status_type status;

   ufef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ufef_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .new_graph     (req_chan.new_graph),
      .end_a         (req_chan.end_a),
      .end_b         (req_chan.end_b),
      .edge_length   (req_chan.edge_length),
      .cmd           (cmd),
      .status        (status),
      .joined        (rsp_chan.joined),
      .is_answer     (rsp_chan.is_answer),
      .length_out    (rsp_chan.length_out),
      .tree_edges    (rsp_chan.tree_edges),
      .tree_complete (rsp_chan.tree_complete)
   );

endmodule
